@@ sv/sfpda_pkg.sv @@
// Shared types and constants for the signed fixed-point to decimal ASCII unit.
`default_nettype none

package sfpda_pkg;

    localparam int VALUE_W         = 48;
    localparam int CHAR_W          = 8;
    localparam int NDIG_W          = 4;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int INT_DIGITS_DEF  = 10;

    localparam logic [NDIG_W-1:0] MAX_FRAC_DIGITS = 4'd9;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2e;

    typedef struct packed {
        logic                       op;
        logic signed [VALUE_W-1:0]  value;
        logic [NDIG_W-1:0]          fraction_digits;
    } num_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_item_t;

    // Largest value that fits in n decimal digits.
    function automatic logic [63:0] pow10_minus1(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p - 64'd1;
    endfunction

endpackage

`default_nettype wire

@@ sv/signed_fixed_point_to_decimal_ascii_unit.sv @@
// Top level: formats one signed fixed-point value as a stream of ASCII characters.
//
//  Channel | Handshake            | Payload      | Meaning
//  num     | num_valid/num_stall  | num_item_t   | value, format, fraction digit count
//  text    | text_valid/text_stall| text_item_t  | one character, last flag
//
// After acceptance an item goes through the magnitude step, bit-serial BCD conversion of
// the integer part (skipped when the integer part saturates), the sign step (carrying '-'
// when negative), the integer digits with leading zeros dropped, and, when op is set, the
// '.' and each fraction digit. A new item is accepted only once the unit is back in idle.
// Reset (asynchronous, active low) clears the control state only; a stall on text holds
// the output register and pauses character emission.
`default_nettype none

module signed_fixed_point_to_decimal_ascii_unit #(
    parameter int FRAC_BITS  = sfpda_pkg::FRAC_BITS_DEF,
    parameter int INT_DIGITS = sfpda_pkg::INT_DIGITS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    num_valid,
    output logic                   num_stall,
    input  wire sfpda_pkg::num_item_t num,
    output logic                   text_valid,
    input  wire                    text_stall,
    output sfpda_pkg::text_item_t  text
);
    import sfpda_pkg::*;

    localparam int IW = VALUE_W - FRAC_BITS;
    localparam int BW = 4 * INT_DIGITS;
    localparam int CW = $clog2(IW + 1);
    localparam logic [63:0] CAP = pow10_minus1(INT_DIGITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAG  = 3'd1;
    localparam logic [2:0] ST_CONV = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_INT  = 3'd4;
    localparam logic [2:0] ST_DOT  = 3'd5;
    localparam logic [2:0] ST_FRAC = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic                 op_reg, op_next;
    logic                 neg_reg, neg_next;
    logic [VALUE_W-1:0]   raw_reg, raw_next;
    logic [NDIG_W-1:0]    nd_reg, nd_next;
    logic [IW-1:0]        shift_reg, shift_next;
    logic [BW-1:0]        bcd_reg, bcd_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 started_reg, started_next;
    logic                 out_valid_reg;
    text_item_t           out_data_reg;

    logic                 accept;
    logic                 can_emit;
    logic                 emit;
    text_item_t           emit_data;
    logic [VALUE_W-1:0]   mag;
    logic [IW-1:0]        int_part;
    logic [BW-1:0]        bcd_adj;
    logic [3:0]           top_digit;
    logic [FRAC_BITS+3:0] frac_times10;

    assign num_stall  = (state_reg != ST_IDLE);
    assign accept     = num_valid && !num_stall;
    assign can_emit   = !out_valid_reg || !text_stall;
    assign text_valid = out_valid_reg;
    assign text       = out_data_reg;

    assign mag      = neg_reg ? (~raw_reg + VALUE_W'(1)) : raw_reg;
    assign int_part = mag[VALUE_W-1:FRAC_BITS];
    assign top_digit = bcd_reg[BW-1 -: 4];
    assign frac_times10 = ({4'b0, frac_reg} << 3) + ({4'b0, frac_reg} << 1);

    // Double-dabble correction: every BCD digit of five or more gets three added.
    always_comb begin
        for (int i = 0; i < INT_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        neg_next     = neg_reg;
        raw_next     = raw_reg;
        nd_next      = nd_reg;
        shift_next   = shift_reg;
        bcd_next     = bcd_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        emit         = 1'b0;
        emit_data    = '{character: ASCII_ZERO, last: 1'b0};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = num.op;
                    raw_next   = num.value;
                    neg_next   = num.value[VALUE_W-1];
                    nd_next    = (num.fraction_digits > MAX_FRAC_DIGITS) ?
                                 MAX_FRAC_DIGITS : num.fraction_digits;
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                frac_next = mag[FRAC_BITS-1:0];
                if (64'(int_part) > CAP) begin
                    // Too many digits for the display: show all nines.
                    bcd_next   = {INT_DIGITS{4'd9}};
                    state_next = ST_SIGN;
                end else begin
                    bcd_next   = '0;
                    shift_next = int_part;
                    cnt_next   = CW'(IW);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next   = {bcd_adj[BW-2:0], shift_reg[IW-1]};
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                cnt_next     = CW'(INT_DIGITS - 1);
                started_next = 1'b0;
                if (!neg_reg) begin
                    state_next = ST_INT;
                end else if (can_emit) begin
                    emit       = 1'b1;
                    emit_data  = '{character: ASCII_MINUS, last: 1'b0};
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                if (!started_reg && top_digit == 4'd0 && cnt_reg != '0) begin
                    // Leading zero: drop it without a transaction.
                    bcd_next = bcd_reg << 4;
                    cnt_next = cnt_reg - CW'(1);
                end else if (can_emit) begin
                    emit         = 1'b1;
                    emit_data    = '{character: ASCII_ZERO + CHAR_W'(top_digit),
                                     last: (cnt_reg == '0) && !op_reg};
                    started_next = 1'b1;
                    bcd_next     = bcd_reg << 4;
                    cnt_next     = cnt_reg - CW'(1);
                    if (cnt_reg == '0) begin
                        state_next = op_reg ? ST_DOT : ST_IDLE;
                    end
                end
            end
            ST_DOT: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_data  = '{character: ASCII_POINT, last: (nd_reg == '0)};
                    state_next = (nd_reg == '0) ? ST_IDLE : ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_data = '{character: ASCII_ZERO +
                                             CHAR_W'(frac_times10[FRAC_BITS+3:FRAC_BITS]),
                                  last: (nd_reg == NDIG_W'(1))};
                    frac_next = frac_times10[FRAC_BITS-1:0];
                    nd_next   = nd_reg - NDIG_W'(1);
                    if (nd_reg == NDIG_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            nd_reg        <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            nd_reg      <= nd_next;
            started_reg <= started_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (!text_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        op_reg    <= op_next;
        neg_reg   <= neg_next;
        raw_reg   <= raw_next;
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        frac_reg  <= frac_next;
        if (emit) begin
            out_data_reg <= emit_data;
        end
    end

    a_accept_to_mag: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MAG)
        else $error("accepted item did not start magnitude stage");

    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV |-> cnt_reg != '0)
        else $error("conversion running with empty bit count");

    a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FRAC |-> (nd_reg != '0 && nd_reg <= MAX_FRAC_DIGITS))
        else $error("fraction digit count out of range");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid |-> (text.character == ASCII_MINUS || text.character == ASCII_POINT ||
                        (text.character >= ASCII_ZERO && text.character <= ASCII_NINE)))
        else $error("emitted character outside the digit set");

endmodule

`default_nettype wire
